FILE: rtl/perb_pkg.sv
// package for the pixel-engine register block: operation codes, register
// indexes, bounding-box constants and the controller command type
// no dependencies
`timescale 1ns / 1ps

package perb_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 16;
  localparam int SIDES   = 4;
  localparam int SIDE_W  = $clog2(SIDES);
  localparam int S_TDATA_W = 24;  // reg_index + write_data + token_ack, byte padded
  localparam int M_TDATA_W = 24;  // read_data + three flags, byte padded

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_TOKEN  = 3'd2,
    OP_FINISH = 3'd3,
    OP_BOX    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  localparam logic [IDX_W-1:0] IDX_DEPTH      = 4'd0;
  localparam logic [IDX_W-1:0] IDX_BLEND      = 4'd1;
  localparam logic [IDX_W-1:0] IDX_DEST_ALPHA = 4'd2;
  localparam logic [IDX_W-1:0] IDX_ALPHA_MODE = 4'd3;
  localparam logic [IDX_W-1:0] IDX_ALPHA_READ = 4'd4;
  localparam logic [IDX_W-1:0] IDX_CTRL       = 4'd5;
  localparam logic [IDX_W-1:0] IDX_TOKEN      = 4'd6;
  localparam logic [IDX_W-1:0] IDX_BOX_LEFT   = 4'd7;
  localparam logic [IDX_W-1:0] IDX_BOX_RIGHT  = 4'd8;
  localparam logic [IDX_W-1:0] IDX_BOX_TOP    = 4'd9;
  localparam logic [IDX_W-1:0] IDX_BOX_BOTTOM = 4'd10;

  // ctrl register bits
  localparam int CTRL_TOKEN_EN  = 0;
  localparam int CTRL_FINISH_EN = 1;
  localparam int CTRL_TOKEN_CLR = 2;
  localparam int CTRL_FINISH_CLR = 3;

  // clear mask bits
  localparam int CLR_TOKEN  = 0;
  localparam int CLR_FINISH = 1;

  localparam logic [DATA_W-1:0] UNKNOWN_READ = 16'd1;

  // side order: left, right, top, bottom
  localparam logic [SIDES-1:0][DATA_W-1:0] BOX_LIMIT =
    {16'd479, 16'd478, 16'd607, 16'd606};
  localparam logic [SIDES-1:0][DATA_W-1:0] BOX_RESET =
    {16'h00A0, 16'h0080, 16'h00A0, 16'h0080};

  typedef struct packed {
    logic exec;  // capture the incoming word and update state
  } perb_cmd_t;

endpackage

FILE: rtl/perb_ctrl.sv
// controller for the pixel-engine register block: input/output handshake
// and the output register occupancy; uses perb_pkg
`timescale 1ns / 1ps

module perb_ctrl
  import perb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output perb_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  // the output word can be replaced in the cycle it is taken
  assign s_tready = (state == ST_EMPTY) || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_FULL);
  assign cmd.exec = accept;

  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (m_tready && !accept) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word did not produce a result");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !s_tvalid) |=> !m_tvalid)
    else $error("result repeated after being taken");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule

FILE: rtl/perb_datapath.sv
// datapath for the pixel-engine register block: register file, pending
// flags, bounding box and the output word register; uses perb_pkg
`timescale 1ns / 1ps

module perb_datapath
  import perb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  perb_cmd_t         cmd,
  input  logic [OP_W-1:0]   op,
  input  logic [IDX_W-1:0]  reg_index,
  input  logic [DATA_W-1:0] write_data,
  input  logic              token_ack,
  output logic [DATA_W-1:0] read_data,
  output logic              token_irq,
  output logic              finish_irq,
  output logic              box_active
);

  logic [DATA_W-1:0] depth_conf, depth_conf_next;
  logic [DATA_W-1:0] blend_conf, blend_conf_next;
  logic [DATA_W-1:0] dest_alpha_conf, dest_alpha_conf_next;
  logic [DATA_W-1:0] alpha_mode_conf, alpha_mode_conf_next;
  logic [DATA_W-1:0] alpha_read_conf, alpha_read_conf_next;
  logic              token_enable, token_enable_next;
  logic              finish_enable, finish_enable_next;
  logic              token_pending, token_pending_next;
  logic              finish_pending, finish_pending_next;
  logic [DATA_W-1:0] token_value, token_value_next;
  logic [SIDES-1:0][DATA_W-1:0] box_sides, box_sides_next;
  logic              box_active_flag, box_active_flag_next;
  logic [DATA_W-1:0] rd;

  logic [SIDE_W-1:0] rd_side;
  logic [DATA_W-1:0] box_raw, box_clamped;

  // bbox read index 7..10 maps to side 0..3
  assign rd_side     = reg_index[SIDE_W-1:0] + SIDE_W'(1);
  assign box_raw     = box_sides[rd_side];
  assign box_clamped = (box_raw > BOX_LIMIT[rd_side]) ? BOX_LIMIT[rd_side] : box_raw;

  always_comb begin
    depth_conf_next      = depth_conf;
    blend_conf_next      = blend_conf;
    dest_alpha_conf_next = dest_alpha_conf;
    alpha_mode_conf_next = alpha_mode_conf;
    alpha_read_conf_next = alpha_read_conf;
    token_enable_next    = token_enable;
    finish_enable_next   = finish_enable;
    token_pending_next   = token_pending;
    finish_pending_next  = finish_pending;
    token_value_next     = token_value;
    box_sides_next       = box_sides;
    box_active_flag_next = box_active_flag;
    rd                   = '0;
    case (op_t'(op))
      OP_READ: begin
        case (reg_index)
          IDX_DEPTH:      rd = depth_conf;
          IDX_BLEND:      rd = blend_conf;
          IDX_DEST_ALPHA: rd = dest_alpha_conf;
          IDX_ALPHA_MODE: rd = alpha_mode_conf;
          IDX_ALPHA_READ: rd = alpha_read_conf;
          IDX_CTRL:       rd = {14'd0, finish_enable, token_enable};
          IDX_TOKEN:      rd = token_value;
          IDX_BOX_LEFT, IDX_BOX_RIGHT, IDX_BOX_TOP, IDX_BOX_BOTTOM: begin
            // left/top even, right/bottom odd
            rd = {box_clamped[DATA_W-1:1], rd_side[0]};
            box_active_flag_next = 1'b0;
          end
          default:        rd = UNKNOWN_READ;
        endcase
      end
      OP_WRITE: begin
        case (reg_index)
          IDX_DEPTH:      depth_conf_next      = write_data;
          IDX_BLEND:      blend_conf_next      = write_data;
          IDX_DEST_ALPHA: dest_alpha_conf_next = write_data;
          IDX_ALPHA_MODE: alpha_mode_conf_next = write_data;
          IDX_ALPHA_READ: alpha_read_conf_next = write_data;
          IDX_CTRL: begin
            token_enable_next  = write_data[CTRL_TOKEN_EN];
            finish_enable_next = write_data[CTRL_FINISH_EN];
            if (write_data[CTRL_TOKEN_CLR])  token_pending_next  = 1'b0;
            if (write_data[CTRL_FINISH_CLR]) finish_pending_next = 1'b0;
          end
          default: ;
        endcase
      end
      OP_TOKEN: begin
        token_value_next = write_data;
        if (token_ack) token_pending_next = 1'b1;
      end
      OP_FINISH: finish_pending_next = 1'b1;
      OP_BOX: begin
        if (reg_index[IDX_W-1:SIDE_W] == '0) begin
          box_sides_next[reg_index[SIDE_W-1:0]] = write_data;
          box_active_flag_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (write_data[CLR_TOKEN])  token_pending_next  = 1'b0;
        if (write_data[CLR_FINISH]) finish_pending_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_conf      <= '0;
      blend_conf      <= '0;
      dest_alpha_conf <= '0;
      alpha_mode_conf <= '0;
      alpha_read_conf <= '0;
      token_enable    <= 1'b0;
      finish_enable   <= 1'b0;
      token_pending   <= 1'b0;
      finish_pending  <= 1'b0;
      token_value     <= '0;
      box_sides       <= BOX_RESET;
      box_active_flag <= 1'b0;
    end else if (cmd.exec) begin
      depth_conf      <= depth_conf_next;
      blend_conf      <= blend_conf_next;
      dest_alpha_conf <= dest_alpha_conf_next;
      alpha_mode_conf <= alpha_mode_conf_next;
      alpha_read_conf <= alpha_read_conf_next;
      token_enable    <= token_enable_next;
      finish_enable   <= finish_enable_next;
      token_pending   <= token_pending_next;
      finish_pending  <= finish_pending_next;
      token_value     <= token_value_next;
      box_sides       <= box_sides_next;
      box_active_flag <= box_active_flag_next;
    end
  end

  // output word, flags sampled after the update
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data  <= rd;
      token_irq  <= token_pending_next && token_enable_next;
      finish_irq <= finish_pending_next && finish_enable_next;
      box_active <= box_active_flag_next;
    end
  end

  a_ctrl_read_narrow: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == OP_READ && reg_index == IDX_CTRL)
      |=> read_data[DATA_W-1:2] == '0)
    else $error("ctrl read returned clear bits");

  a_box_read_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == OP_READ && (reg_index == IDX_BOX_LEFT ||
     reg_index == IDX_BOX_RIGHT || reg_index == IDX_BOX_TOP ||
     reg_index == IDX_BOX_BOTTOM)) |=> (!box_active && !box_active_flag))
    else $error("bbox read left box active set");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == OP_CLEAR && write_data[CLR_TOKEN] && write_data[CLR_FINISH])
      |=> (!token_pending && !finish_pending))
    else $error("clear of both pending flags failed");

endmodule

FILE: rtl/pixel_engine_register_block_top.sv
// top level of the pixel-engine register block: controller and datapath
// depends on perb_pkg, perb_ctrl and perb_datapath
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+-------------------------------
//   input    | s_tvalid s_tready s_tdata s_tuser | op in tuser, index/data/ack
//   output   | m_tvalid m_tready m_tdata         | read data and three flags
//
// one word per cycle while the sink is ready; each accepted word is decoded and
// its result lands in the output register in the cycle after it is accepted
// the output register is replaced in the cycle its word is taken, which
// keeps the rate at one word per clock while the sink is ready
// a stalled sink holds the output word and stalls the input
// rst is synchronous: config and flags to zero, box sides to 128/160/128/160
`timescale 1ns / 1ps

module pixel_engine_register_block_top
  import perb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [3:0] reg_index, [19:4] write_data,
                                         // [20] token_ack, [23:21] zero
  input  logic [OP_W-1:0]      s_tuser,  // [2:0] op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // [15:0] read_data, [16] token_irq,
                                         // [17] finish_irq, [18] box_active,
                                         // [23:19] zero
);

  perb_cmd_t         cmd;
  logic [DATA_W-1:0] read_data;
  logic              token_irq;
  logic              finish_irq;
  logic              box_active;

  perb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  perb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (s_tuser),
    .reg_index  (s_tdata[IDX_W-1:0]),
    .write_data (s_tdata[IDX_W+DATA_W-1:IDX_W]),
    .token_ack  (s_tdata[IDX_W+DATA_W]),
    .read_data  (read_data),
    .token_irq  (token_irq),
    .finish_irq (finish_irq),
    .box_active (box_active)
  );

  assign m_tdata = {(M_TDATA_W-DATA_W-3)'(0), box_active, finish_irq, token_irq, read_data};

endmodule

FILE: test/tb_top.sv
// self-checking bench for the pixel-engine register block: a directed table,
// then random words, with a running model of the registers predicting each word
// depends on perb_pkg and pixel_engine_register_block_top
`timescale 1ns / 1ps

module tb_top;
  import perb_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 1080;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 8;

  // output word, lowest field last
  typedef struct packed {
    logic [4:0]        pad;
    logic              box_flag;
    logic              fin_irq;
    logic              tok_irq;
    logic [DATA_W-1:0] rd_data;
  } engine_word_t;

  // input word, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic              ack;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  idx;
  } request_word_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic              ack;
    logic              typed;
    engine_word_t      want;
  } stim_row_t;

  localparam engine_word_t NOT_TYPED = '0;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0]      s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  // register image kept by the bench
  logic [DATA_W-1:0] conf_q [5];
  logic              tok_en, fin_en, tok_pend, fin_pend, box_live;
  logic [DATA_W-1:0] tok_val;
  logic [DATA_W-1:0] side_q [SIDES];

  engine_word_t expected_words [$];
  logic         typed_now;
  engine_word_t typed_word;
  int           fail_count = 0;
  int           results_seen = 0;

  // typed rows hold values readable straight off the register map
  stim_row_t directed_rows [26] = '{
    '{OP_READ,   IDX_CTRL,       16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'h0000}},
    '{OP_READ,   IDX_TOKEN,      16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'h0000}},
    '{OP_READ,   IDX_BOX_LEFT,   16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'd128}},
    '{OP_READ,   IDX_BOX_RIGHT,  16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'd161}},
    '{OP_READ,   IDX_BOX_TOP,    16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'd128}},
    '{OP_READ,   IDX_BOX_BOTTOM, 16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'd161}},
    '{OP_READ,   4'd15,          16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, UNKNOWN_READ}},
    '{OP_WRITE,  IDX_DEPTH,      16'hFFFF, 1'b1, 1'b0, NOT_TYPED},
    '{OP_READ,   IDX_DEPTH,      16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF}},
    '{OP_WRITE,  IDX_CTRL,       16'h0003, 1'b0, 1'b0, NOT_TYPED},
    '{OP_TOKEN,  IDX_DEPTH,      16'hFFFF, 1'b1, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b1, 16'h0000}},
    '{OP_WRITE,  IDX_TOKEN,      16'h1234, 1'b0, 1'b0, NOT_TYPED},
    '{OP_READ,   IDX_TOKEN,      16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b1, 16'hFFFF}},
    '{OP_FINISH, IDX_DEPTH,      16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b1, 16'h0000}},
    '{OP_CLEAR,  IDX_DEPTH,      16'h0001, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b0, 16'h0000}},
    '{OP_WRITE,  IDX_CTRL,       16'h000B, 1'b0, 1'b0, NOT_TYPED},
    '{OP_TOKEN,  IDX_DEPTH,      16'h0000, 1'b0, 1'b0, NOT_TYPED},
    '{OP_BOX,    4'd0,           16'hFFFF, 1'b0, 1'b0, NOT_TYPED},
    '{OP_BOX,    4'd3,           16'h0000, 1'b0, 1'b0, NOT_TYPED},
    '{OP_BOX,    4'd5,           16'h0007, 1'b0, 1'b0, NOT_TYPED},
    '{OP_READ,   IDX_BOX_LEFT,   16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'd606}},
    '{OP_READ,   IDX_BOX_BOTTOM, 16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{OP_WRITE,  IDX_BOX_RIGHT,  16'h0000, 1'b0, 1'b0, NOT_TYPED},
    '{OP_SPARE_LO, 4'd15,        16'hFFFF, 1'b1, 1'b0, NOT_TYPED},
    '{OP_SPARE_HI, 4'd0,         16'hFFFF, 1'b1, 1'b0, NOT_TYPED},
    '{OP_READ,   IDX_CTRL,       16'h0000, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 16'h0003}}
  };

  pixel_engine_register_block_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // applies one word to the register image and returns the word it gives back
  function automatic engine_word_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic ack);
    engine_word_t      w;
    logic [DATA_W-1:0] v;
    int                side;
    w = '0;
    case (op)
      OP_READ: begin
        if (idx <= IDX_ALPHA_READ) begin
          w.rd_data = conf_q[idx];
        end else if (idx == IDX_CTRL) begin
          w.rd_data = {14'd0, fin_en, tok_en};
        end else if (idx == IDX_TOKEN) begin
          w.rd_data = tok_val;
        end else if (idx <= IDX_BOX_BOTTOM) begin
          side = idx - IDX_BOX_LEFT;
          v = side_q[side];
          if (v > BOX_LIMIT[side]) v = BOX_LIMIT[side];
          // left and top even, right and bottom odd
          v[0] = side[0];
          box_live = 1'b0;
          w.rd_data = v;
        end else begin
          w.rd_data = UNKNOWN_READ;
        end
      end
      OP_WRITE: begin
        if (idx <= IDX_ALPHA_READ) begin
          conf_q[idx] = data;
        end else if (idx == IDX_CTRL) begin
          if (data[CTRL_TOKEN_CLR]) tok_pend = 1'b0;
          if (data[CTRL_FINISH_CLR]) fin_pend = 1'b0;
          tok_en = data[CTRL_TOKEN_EN];
          fin_en = data[CTRL_FINISH_EN];
        end
      end
      OP_TOKEN: begin
        tok_val = data;
        if (ack) tok_pend = 1'b1;
      end
      OP_FINISH: begin
        fin_pend = 1'b1;
      end
      OP_BOX: begin
        if (idx < SIDES) begin
          side_q[idx[SIDE_W-1:0]] = data;
          box_live = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (data[CLR_TOKEN]) tok_pend = 1'b0;
        if (data[CLR_FINISH]) fin_pend = 1'b0;
      end
      default: begin
      end
    endcase
    w.tok_irq  = tok_pend & tok_en;
    w.fin_irq  = fin_pend & fin_en;
    w.box_flag = box_live;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic offer_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data, input logic ack,
                            input logic typed, input engine_word_t want, input int gap);
    request_word_t req;
    req = '{3'd0, ack, data, idx};
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= op;
    s_tdata    <= req;
    typed_now  <= typed;
    typed_word <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  // compare outgoing words first, then log the word just taken in
  always @(posedge clk) begin : scoreboard
    engine_word_t  got, want;
    request_word_t req;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("read_data", want.rd_data, got.rd_data);
          check_field("token_irq", want.tok_irq, got.tok_irq);
          check_field("finish_irq", want.fin_irq, got.fin_irq);
          check_field("box_active", want.box_flag, got.box_flag);
          check_field("padding", want.pad, got.pad);
        end
      end
      if (s_tvalid && s_tready) begin
        req = s_tdata;
        want = apply_request(s_tuser, req.idx, req.data, req.ack);
        expected_words.push_back(typed_now ? typed_word : want);
      end
    end
  end

  initial begin : sink_side
    int  gap, burst;
    bit  held;
    held = 1'b0;
    m_tready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      // long hold-off so the block backs up into its input
      if (!held && results_seen >= 250) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      burst = $urandom_range(1, 24);
      m_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = (results_seen >= 700 && results_seen < 850) ? 0 : pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic              ack;
    int                r;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= '0;
    typed_now  <= 1'b0;
    typed_word <= '0;
    for (int k = 0; k < 5; k++) conf_q[k] = '0;
    for (int k = 0; k < SIDES; k++) side_q[k] = BOX_RESET[k];
    tok_en = 1'b0;
    fin_en = 1'b0;
    tok_pend = 1'b0;
    fin_pend = 1'b0;
    tok_val = '0;
    box_live = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      offer_word(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].data,
                 directed_rows[k].ack, directed_rows[k].typed, directed_rows[k].want,
                 pick_gap());

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      r    = $urandom_range(0, 99);
      ack  = 1'($urandom_range(0, 1));
      data = DATA_W'($urandom);
      idx  = IDX_W'($urandom_range(0, 15));
      if (r < 30) begin
        op = OP_READ;
      end else if (r < 55) begin
        op = OP_WRITE;
        if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, 5));
      end else if (r < 65) begin
        op = OP_TOKEN;
      end else if (r < 73) begin
        op = OP_FINISH;
      end else if (r < 88) begin
        op = OP_BOX;
        if ($urandom_range(0, 4) != 0) idx = IDX_W'($urandom_range(0, SIDES - 1));
        // keep plenty of side values around the clamp limits
        case ($urandom_range(0, 3))
          0: data = DATA_W'($urandom_range(596, 616));
          1: data = DATA_W'($urandom_range(468, 489));
          2: data = DATA_W'($urandom_range(0, 255));
          default: begin
          end
        endcase
      end else if (r < 96) begin
        op = OP_CLEAR;
      end else begin
        op = (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      offer_word(op, idx, data, ack, 1'b0, NOT_TYPED,
                 (i >= 400 && i < 560) ? 0 : pick_gap());
    end
    s_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
